/* hdl/box_distance_point_clustering_defines.svh */
// assertion macros for the box distance point clustering block
`ifndef BOX_DISTANCE_POINT_CLUSTERING_DEFINES_SVH
`define BOX_DISTANCE_POINT_CLUSTERING_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BDPC_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define BDPC_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bdpc_pkg.sv */
// shared types and constants of the box distance point clustering block
`timescale 1ns / 1ps
`default_nettype none
package bdpc_pkg;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMP_RADIUS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_RADIUS = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIX_EN      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GEO_EN      = 4'd3;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] samp_coord;
    logic signed [31:0] line_coord;
    logic signed [31:0] lon_coord;
    logic signed [31:0] lat_coord;
    logic               last_point;
    logic [9:0]         point_index;
  } in_item_t;

  typedef struct packed {
    logic [10:0]        cluster_id;
    logic signed [31:0] samp_centroid;
    logic signed [31:0] line_centroid;
    logic signed [31:0] lon_centroid;
    logic signed [31:0] lat_centroid;
    logic [10:0]        cluster_total;
    logic               index_invalid;
    logic               load_overflow;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic read_start;
    logic cl_init;
    logic head_issue;
    logic head_open;
    logic head_skip;
    logic scan_issue;
    logic scan_eval;
    logic save;
    logic id_cap;
    logic sum_cap;
    logic div_start;
    logic div_cap;
    logic res_load;
  } dp_cmd_t;

  typedef struct packed {
    logic i_end;
    logic j_end;
    logic head_free;
    logic rd_bad;
    logic div_done;
    logic k_last;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

/* hdl/bdpc_ram.sv */
// generic one-write one-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module bdpc_ram #(
  parameter int W = 32,
  parameter int D = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hdl/bdpc_div.sv */
// sequential signed by unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module bdpc_div #(
  parameter int NW = 42,
  parameter int DW = 11
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [NW-1:0] num,
  input  wire logic [DW-1:0]        den,
  output logic                      done,
  output logic [31:0]               quo
);
  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   mag_r;
  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   den_r;
  logic            neg_r;
  logic [CNTW-1:0] cnt_r;
  logic            done_r;
  logic [DW:0]     sh;
  logic            ge;
  logic [DW-1:0]   rem_nxt;
  logic [NW-1:0]   q_signed;

  assign sh = {rem_r, mag_r[NW-1]};
  assign ge = sh >= {1'b0, den_r};
  assign rem_nxt = ge ? DW'(sh - {1'b0, den_r}) : DW'(sh);
  assign q_signed = neg_r ? (~mag_r + NW'(1)) : mag_r;
  assign quo = q_signed[31:0];
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNTW'(NW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= num[NW-1] ? NW'(-num) : NW'(num);
      neg_r <= num[NW-1];
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      mag_r <= {mag_r[NW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end
endmodule
`default_nettype wire

/* hdl/bdpc_ctrl.sv */
// controller state machine for loading, clustering and reading
`timescale 1ns / 1ps
`default_nettype none
module bdpc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_req,
  input  wire logic               in_last,
  output logic                    in_stall,
  input  wire bdpc_pkg::dp_stat_t stat,
  output bdpc_pkg::dp_cmd_t       cmd
);
  import bdpc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_HEAD_RD, S_HEAD_EV, S_SCAN_RD, S_SCAN_EV, S_SAVE,
    S_ID_EV, S_SUM_RD, S_SUM_EV, S_DIV_GO, S_DIV_WAIT, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req == REQ_READ) begin
            cmd.read_start = 1'b1;
            state_nxt = S_ID_EV;
          end else begin
            cmd.load = 1'b1;
            if (in_last) begin
              cmd.cl_init = 1'b1;
              state_nxt = S_HEAD_RD;
            end
          end
        end
      end
      S_HEAD_RD: begin
        if (stat.i_end) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.head_issue = 1'b1;
          state_nxt = S_HEAD_EV;
        end
      end
      S_HEAD_EV: begin
        if (stat.head_free) begin
          cmd.head_open = 1'b1;
          state_nxt = S_SCAN_RD;
        end else begin
          cmd.head_skip = 1'b1;
          state_nxt = S_HEAD_RD;
        end
      end
      S_SCAN_RD: begin
        if (stat.j_end) begin
          state_nxt = S_SAVE;
        end else begin
          cmd.scan_issue = 1'b1;
          state_nxt = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        cmd.scan_eval = 1'b1;
        state_nxt = S_SCAN_RD;
      end
      S_SAVE: begin
        cmd.save = 1'b1;
        state_nxt = S_HEAD_RD;
      end
      S_ID_EV: begin
        cmd.id_cap = 1'b1;
        state_nxt = stat.rd_bad ? S_DONE : S_SUM_RD;
      end
      S_SUM_RD: begin
        state_nxt = S_SUM_EV;
      end
      S_SUM_EV: begin
        cmd.sum_cap = 1'b1;
        state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.div_cap = 1'b1;
          state_nxt = stat.k_last ? S_DONE : S_DIV_GO;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

/* hdl/bdpc_dp.sv */
// datapath: point, cluster and sum memories, scan compare, accumulators, result
`timescale 1ns / 1ps
`default_nettype none
module bdpc_dp #(
  parameter int MAX_POINTS   = 1024,
  parameter int MAX_CLUSTERS = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire bdpc_pkg::in_item_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output bdpc_pkg::out_item_t                      out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [bdpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bdpc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire bdpc_pkg::dp_cmd_t                   cmd,
  output bdpc_pkg::dp_stat_t                       stat
);
  import bdpc_pkg::*;

  localparam int PW   = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int IDW  = $clog2(MAX_CLUSTERS + 1);
  localparam int CAW  = $clog2(MAX_CLUSTERS);
  localparam int SUMW = 32 + $clog2(MAX_POINTS);
  localparam int SRW  = 4 * SUMW + CW;

  logic [15:0]           samp_rad_r, line_rad_r;
  logic                  pix_en_r, geo_en_r;
  logic [CW-1:0]         loaded_r;
  logic [IDW-1:0]        clusters_r;
  logic                  ovf_r;
  logic                  out_valid_r;
  out_item_t             out_r;
  logic [CW-1:0]         i_r, j_r;
  logic [IDW-1:0]        c_r;
  logic signed [31:0]    head_samp_r, head_line_r;
  logic signed [SUMW-1:0] acc_r [4];
  logic [CW-1:0]         cnt_r;
  logic                  invalid_r, bad_r;
  logic [IDW-1:0]        id_r;
  logic signed [SUMW-1:0] sum_r [4];
  logic [CW-1:0]         msz_r;
  logic [1:0]            k_r;
  logic signed [31:0]    res_r [4];

  logic [CW-1:0]         eff_loaded;
  logic                  full;
  logic                  pt_we, cl_we;
  logic [PW-1:0]         pt_raddr, cl_waddr, cl_raddr;
  logic [IDW-1:0]        cl_wdata, cl_rdata;
  logic [127:0]          pt_rdata;
  logic [SRW-1:0]        sr_wdata, sr_rdata;
  logic signed [31:0]    p_samp, p_line, p_lon, p_lat;
  logic signed [32:0]    ds, dl;
  logic [32:0]           ads, adl;
  logic                  join_ok;
  logic                  div_done;
  logic [31:0]           div_quo;

  assign cfg_ready = 1'b1;
  assign eff_loaded = (clusters_r != '0) ? '0 : loaded_r;
  assign full = (eff_loaded == CW'(MAX_POINTS));

  assign p_samp = pt_rdata[31:0];
  assign p_line = pt_rdata[63:32];
  assign p_lon  = pt_rdata[95:64];
  assign p_lat  = pt_rdata[127:96];

  assign ds  = {p_samp[31], p_samp} - {head_samp_r[31], head_samp_r};
  assign dl  = {p_line[31], p_line} - {head_line_r[31], head_line_r};
  assign ads = ds[32] ? 33'(-ds) : 33'(ds);
  assign adl = dl[32] ? 33'(-dl) : 33'(dl);
  assign join_ok = (cl_rdata == '0) && (ads <= {9'd0, samp_rad_r, 8'd0})
                   && (adl <= {9'd0, line_rad_r, 8'd0});

  assign pt_we    = cmd.load && !full;
  assign pt_raddr = cmd.head_issue ? PW'(i_r) : PW'(j_r);

  assign cl_we    = pt_we || cmd.head_open || (cmd.scan_eval && join_ok);
  assign cl_waddr = cmd.load ? PW'(eff_loaded) : (cmd.head_open ? PW'(i_r) : PW'(j_r));
  assign cl_wdata = cmd.load ? '0 : (cmd.head_open ? IDW'(clusters_r + IDW'(1))
                                                   : IDW'(c_r + IDW'(1)));
  assign cl_raddr = cmd.read_start ? PW'(in_data.point_index)
                  : (cmd.head_issue ? PW'(i_r) : PW'(j_r));

  assign sr_wdata = {cnt_r, acc_r[3], acc_r[2], acc_r[1], acc_r[0]};

  bdpc_ram #(.W(128), .D(MAX_POINTS)) u_pt_ram (
    .clk(clk), .we(pt_we), .waddr(PW'(eff_loaded)),
    .wdata({in_data.lat_coord, in_data.lon_coord, in_data.line_coord, in_data.samp_coord}),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  bdpc_ram #(.W(IDW), .D(MAX_POINTS)) u_cl_ram (
    .clk(clk), .we(cl_we), .waddr(cl_waddr), .wdata(cl_wdata),
    .raddr(cl_raddr), .rdata(cl_rdata)
  );

  bdpc_ram #(.W(SRW), .D(MAX_CLUSTERS)) u_sum_ram (
    .clk(clk), .we(cmd.save), .waddr(CAW'(c_r)), .wdata(sr_wdata),
    .raddr(CAW'(id_r - IDW'(1))), .rdata(sr_rdata)
  );

  bdpc_div #(.NW(SUMW), .DW(CW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(sum_r[k_r]),
    .den(msz_r), .done(div_done), .quo(div_quo)
  );

  assign stat.i_end     = (i_r == loaded_r);
  assign stat.j_end     = (j_r == loaded_r);
  assign stat.head_free = (cl_rdata == '0) && (clusters_r < IDW'(MAX_CLUSTERS));
  assign stat.rd_bad    = invalid_r || (cl_rdata == '0);
  assign stat.div_done  = div_done;
  assign stat.k_last    = (k_r == 2'd3);
  assign stat.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samp_rad_r  <= 16'd1;
      line_rad_r  <= 16'd1;
      pix_en_r    <= 1'b1;
      geo_en_r    <= 1'b0;
      loaded_r    <= '0;
      clusters_r  <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SAMP_RADIUS: samp_rad_r <= cfg_data;
          CFG_LINE_RADIUS: line_rad_r <= cfg_data;
          CFG_PIX_EN:      pix_en_r   <= cfg_data[0];
          CFG_GEO_EN:      geo_en_r   <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        clusters_r <= '0;
        if (full) begin
          loaded_r <= eff_loaded;
          ovf_r    <= 1'b1;
        end else begin
          loaded_r <= eff_loaded + CW'(1);
          ovf_r    <= (clusters_r != '0) ? 1'b0 : ovf_r;
        end
      end
      if (cmd.head_open) begin
        clusters_r <= clusters_r + IDW'(1);
      end
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.cl_init) begin
      i_r <= '0;
    end
    if (cmd.head_skip || cmd.save) begin
      i_r <= i_r + CW'(1);
    end
    if (cmd.head_open) begin
      j_r         <= i_r + CW'(1);
      c_r         <= clusters_r;
      head_samp_r <= p_samp;
      head_line_r <= p_line;
      acc_r[0]    <= SUMW'(p_samp);
      acc_r[1]    <= SUMW'(p_line);
      acc_r[2]    <= SUMW'(p_lon);
      acc_r[3]    <= SUMW'(p_lat);
      cnt_r       <= CW'(1);
    end
    if (cmd.scan_eval) begin
      j_r <= j_r + CW'(1);
      if (join_ok) begin
        acc_r[0] <= acc_r[0] + SUMW'(p_samp);
        acc_r[1] <= acc_r[1] + SUMW'(p_line);
        acc_r[2] <= acc_r[2] + SUMW'(p_lon);
        acc_r[3] <= acc_r[3] + SUMW'(p_lat);
        cnt_r    <= cnt_r + CW'(1);
      end
    end
    if (cmd.read_start) begin
      invalid_r <= (32'(in_data.point_index) >= 32'(loaded_r));
    end
    if (cmd.id_cap) begin
      id_r  <= invalid_r ? '0 : cl_rdata;
      bad_r <= stat.rd_bad;
    end
    if (cmd.sum_cap) begin
      sum_r[0] <= sr_rdata[SUMW-1:0];
      sum_r[1] <= sr_rdata[2*SUMW-1:SUMW];
      sum_r[2] <= sr_rdata[3*SUMW-1:2*SUMW];
      sum_r[3] <= sr_rdata[4*SUMW-1:3*SUMW];
      msz_r    <= sr_rdata[SRW-1:4*SUMW];
      k_r      <= 2'd0;
    end
    if (cmd.div_cap) begin
      res_r[k_r] <= div_quo;
      k_r        <= k_r + 2'd1;
    end
    if (cmd.res_load) begin
      out_r.cluster_id    <= 11'(id_r);
      out_r.samp_centroid <= (bad_r || !pix_en_r) ? '0 : res_r[0];
      out_r.line_centroid <= (bad_r || !pix_en_r) ? '0 : res_r[1];
      out_r.lon_centroid  <= (bad_r || !geo_en_r) ? '0 : res_r[2];
      out_r.lat_centroid  <= (bad_r || !geo_en_r) ? '0 : res_r[3];
      out_r.cluster_total <= 11'(clusters_r);
      out_r.index_invalid <= invalid_r;
      out_r.load_overflow <= ovf_r;
    end
  end
endmodule
`default_nettype wire

/* hdl/box_distance_point_clustering.sv */
// top level of the box distance point clustering block
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall | bdpc_pkg::in_item_t
//  out     | output    | out_valid/out_stall | bdpc_pkg::out_item_t
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// a load of the last point of a set starts clustering of the N loaded points,
// scanning the later points after each head i that opens a cluster
// a read of a valid index divides the four sums in turn on the shared serial divider
// reset is synchronous and active low; memories need no clearing pass
// a result held by out_stall blocks only the next result, not the next transfer
`timescale 1ns / 1ps
`default_nettype none
module box_distance_point_clustering #(
  parameter int MAX_POINTS   = 1024,
  parameter int MAX_CLUSTERS = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire bdpc_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output bdpc_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bdpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bdpc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bdpc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bdpc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_req(in_data.req_type),
    .in_last(in_data.last_point), .in_stall(in_stall), .stat(stat), .cmd(cmd)
  );

  bdpc_dp #(.MAX_POINTS(MAX_POINTS), .MAX_CLUSTERS(MAX_CLUSTERS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .out_valid(out_valid),
    .out_stall(out_stall), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .stat(stat)
  );
endmodule
`default_nettype wire

/* hdl/bdpc_checker.sv */
// port-level checker for the clustering block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "box_distance_point_clustering_defines.svh"
module bdpc_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire bdpc_pkg::in_item_t              in_data,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire bdpc_pkg::out_item_t             out_data
);
  import bdpc_pkg::*;

  `BDPC_AST_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `BDPC_AST_NEXT(a_busy_after_in, in_valid && !in_stall && in_data.req_type == REQ_READ, in_stall, "read transfer not followed by busy")
  `BDPC_AST_NOW(a_invalid_zero, out_valid && out_data.index_invalid, out_data.cluster_id == 11'd0 && out_data.samp_centroid == 32'sd0 && out_data.lat_centroid == 32'sd0, "bad index gave data")
  `BDPC_AST_NOW(a_id_le_total, out_valid, out_data.cluster_id <= out_data.cluster_total, "cluster id above total")
endmodule

bind box_distance_point_clustering bdpc_checker u_bdpc_checker (.*);
`default_nettype wire
